/* rtl/core/double_ended_indexed_queue_unit_defines.svh */
// Assertion macros used by the checker file deiq_checker.sv.
`ifndef DOUBLE_ENDED_INDEXED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_INDEXED_QUEUE_UNIT_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define DEIQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define DEIQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define DEIQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/deiq_pkg.sv */
package deiq_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int REQ_W          = 3;
	localparam int STATUS_W       = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_DROP_FRONT = 3'd2,
		REQ_DROP_BACK  = 3'd3,
		REQ_READ       = 3'd4,
		REQ_WRITE      = 3'd5
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_UNDERFLOW = 2'd3
	} status_t;

endpackage

/* rtl/core/double_ended_indexed_queue_unit.sv */
// A request beat is accepted into stage s1, and its result beat moves from s1 into the
// output register when s1 advances; a stalled output holds s1 and blocks new accepts.
// Throughput: one request per cycle unless the output stalls; each request does at
// most one memory access (read or write), at its accept edge, so none waits on another.
// Reset: asynchronous, active low; empties the queue (head and count to zero) and
// drops any beat in flight. Item memory is not cleared and needs no clearing pass.
module double_ended_indexed_queue_unit #(
	parameter int DEPTH      = deiq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deiq_pkg::DATA_WIDTH_DEF,
	localparam int IDX_W     = $clog2(DEPTH),
	localparam int CNT_W     = $clog2(DEPTH + 1),
	localparam int S_TDATA_W = ((DATA_WIDTH + IDX_W + CNT_W + 7) / 8) * 8,
	localparam int M_TDATA_W = ((DATA_WIDTH + deiq_pkg::STATUS_W + CNT_W + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// data_value, position, drop_amount (low to high), zero padded
	input  logic [S_TDATA_W-1:0]       s_tdata,
	// req_type
	input  logic [deiq_pkg::REQ_W-1:0] s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// read_value, status, used_count (low to high), zero padded
	output logic [M_TDATA_W-1:0]       m_tdata
);

	localparam int SUM_W   = CNT_W + 1;
	localparam int M_PAD_W = M_TDATA_W - DATA_WIDTH - deiq_pkg::STATUS_W - CNT_W;

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	logic                    v_s1;
	logic                    rd_ok_s1;
	deiq_pkg::status_t       status_s1;
	logic [CNT_W-1:0]        count_s1;

	logic                    m_valid_q;
	logic [DATA_WIDTH-1:0]   m_value_q;
	deiq_pkg::status_t       m_status_q;
	logic [CNT_W-1:0]        m_count_q;

	deiq_pkg::req_type_t     req;
	logic [DATA_WIDTH-1:0]   in_value;
	logic [IDX_W-1:0]        in_pos;
	logic [CNT_W-1:0]        in_amount;

	logic                    accept;
	logic                    advance_s1;
	logic                    full;
	logic                    over_drop;
	logic                    out_range;
	logic [CNT_W-1:0]        offset;
	logic [SUM_W-1:0]        off_sum;
	logic [IDX_W-1:0]        slot;
	logic [IDX_W-1:0]        head_dec;

	logic [IDX_W-1:0]        head_d;
	logic [CNT_W-1:0]        count_d;
	deiq_pkg::status_t       status_d;
	logic                    mem_we;
	logic                    mem_re;
	logic [IDX_W-1:0]        mem_addr;

	assign req       = deiq_pkg::req_type_t'(s_tuser);
	assign in_value  = s_tdata[DATA_WIDTH-1:0];
	assign in_pos    = s_tdata[DATA_WIDTH +: IDX_W];
	assign in_amount = s_tdata[DATA_WIDTH + IDX_W +: CNT_W];

	assign advance_s1 = v_s1 && (!m_valid_q || m_tready);
	assign s_tready   = !v_s1 || advance_s1;
	assign accept     = s_tvalid && s_tready;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign over_drop = (in_amount > count_q);
	assign out_range = (CNT_W'(in_pos) >= count_q);
	assign head_dec  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);

	// Logical offset from the front that this request touches.
	always_comb begin
		case (req)
			deiq_pkg::REQ_DROP_FRONT: offset = over_drop ? count_q : in_amount;
			deiq_pkg::REQ_READ, deiq_pkg::REQ_WRITE: offset = CNT_W'(in_pos);
			default: offset = count_q;
		endcase
	end

	// Offset never exceeds DEPTH, so one conditional subtract wraps it.
	assign off_sum = SUM_W'(head_q) + SUM_W'(offset);
	assign slot    = (off_sum >= SUM_W'(DEPTH)) ? IDX_W'(off_sum - SUM_W'(DEPTH))
	                                            : IDX_W'(off_sum);

	always_comb begin
		head_d   = head_q;
		count_d  = count_q;
		status_d = deiq_pkg::ST_OK;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = slot;
		unique case (req)
			deiq_pkg::REQ_PUSH_FRONT: begin
				mem_addr = head_dec;
				if (full) begin
					status_d = deiq_pkg::ST_FULL;
				end else begin
					head_d  = head_dec;
					count_d = count_q + CNT_W'(1);
					mem_we  = 1'b1;
				end
			end
			deiq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					status_d = deiq_pkg::ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					mem_we  = 1'b1;
				end
			end
			deiq_pkg::REQ_DROP_FRONT: begin
				head_d = slot;
				if (over_drop) begin
					count_d  = '0;
					status_d = deiq_pkg::ST_UNDERFLOW;
				end else begin
					count_d = count_q - in_amount;
				end
			end
			deiq_pkg::REQ_DROP_BACK: begin
				if (over_drop) begin
					count_d  = '0;
					status_d = deiq_pkg::ST_UNDERFLOW;
				end else begin
					count_d = count_q - in_amount;
				end
			end
			deiq_pkg::REQ_READ: begin
				if (out_range) begin
					status_d = deiq_pkg::ST_RANGE;
				end else begin
					mem_re = 1'b1;
				end
			end
			deiq_pkg::REQ_WRITE: begin
				if (out_range) begin
					status_d = deiq_pkg::ST_RANGE;
				end else begin
					mem_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Read data holds until the next accepted read, which only happens once s1 has moved on.
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			mem[mem_addr] <= in_value;
		end
		if (accept && mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			v_s1      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_d;
				count_q <= count_d;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance_s1) begin
				v_s1 <= 1'b0;
			end
			if (advance_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1  <= mem_re;
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
		if (advance_s1) begin
			m_value_q  <= rd_ok_s1 ? rd_data_q : '0;
			m_status_q <= status_s1;
			m_count_q  <= count_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, m_count_q, m_status_q, m_value_q};

endmodule

/* rtl/core/deiq_checker.sv */
`include "double_ended_indexed_queue_unit_defines.svh"

module deiq_checker #(
	parameter int DEPTH      = deiq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deiq_pkg::DATA_WIDTH_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1),
	localparam int M_TDATA_W = ((DATA_WIDTH + deiq_pkg::STATUS_W + CNT_W + 7) / 8) * 8
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	logic [DATA_WIDTH-1:0]         value;
	logic [deiq_pkg::STATUS_W-1:0] status;
	logic [CNT_W-1:0]              used;

	assign value  = m_tdata[DATA_WIDTH-1:0];
	assign status = m_tdata[DATA_WIDTH +: deiq_pkg::STATUS_W];
	assign used   = m_tdata[DATA_WIDTH + deiq_pkg::STATUS_W +: CNT_W];

	`DEIQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "result beat changed while stalled")
	`DEIQ_ASSERT_SAME(a_count_cap, clk, arst_n, m_tvalid,
		used <= CNT_W'(DEPTH), "used count above capacity")
	`DEIQ_ASSERT_SAME(a_full_count, clk, arst_n, m_tvalid && status == deiq_pkg::ST_FULL,
		used == CNT_W'(DEPTH), "full status with queue not full")
	`DEIQ_ASSERT_SAME(a_underflow_empty, clk, arst_n,
		m_tvalid && status == deiq_pkg::ST_UNDERFLOW, used == '0,
		"underflow status with queue not empty")
	`DEIQ_ASSERT_SAME(a_value_ok_only, clk, arst_n, m_tvalid && value != '0,
		status == deiq_pkg::ST_OK, "nonzero read value on a failed request")

endmodule

bind double_ended_indexed_queue_unit deiq_checker #(
	.DEPTH(DEPTH),
	.DATA_WIDTH(DATA_WIDTH)
) u_deiq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

/* tb/deiq_result_checker.sv */
`timescale 1ns / 100ps

module deiq_result_checker #(
	parameter int S_W = 56,
	parameter int M_W = 48
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	// data_value, position, drop_amount (low to high), zero padded
	input  logic [S_W-1:0]             s_tdata,
	// req_type
	input  logic [deiq_pkg::REQ_W-1:0] s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	// read_value, status, used_count (low to high), zero padded
	input  logic [M_W-1:0]             m_tdata,
	output int                         fail_count,
	output int                         req_beats,
	output int                         rsp_beats
);
	import deiq_pkg::*;

	localparam int DEPTH  = DEPTH_DEF;
	localparam int DATA_W = DATA_WIDTH_DEF;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		status_t           status;
		logic [CNT_W-1:0]  used_count;
	} deiq_result_t;

	logic [DATA_W-1:0] item_mem [DEPTH];
	logic [IDX_W-1:0]  head_slot = '0;
	logic [CNT_W-1:0]  held_count = '0;
	deiq_result_t      expected_results [$];

	int fails = 0;
	int reqs = 0;
	int rsps = 0;

	assign fail_count = fails;
	assign req_beats  = reqs;
	assign rsp_beats  = rsps;

	function automatic logic [IDX_W-1:0] slot_at(input int offset);
		return IDX_W'((int'(head_slot) + offset) % DEPTH);
	endfunction

	function automatic deiq_result_t apply_request(
		input logic [REQ_W-1:0]  kind,
		input logic [DATA_W-1:0] value,
		input logic [IDX_W-1:0]  pos,
		input logic [CNT_W-1:0]  amount
	);
		deiq_result_t r;
		r.read_value = '0;
		r.status = ST_OK;
		case (kind)
			REQ_PUSH_FRONT: begin
				if (held_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					head_slot = slot_at(DEPTH - 1);
					item_mem[head_slot] = value;
					held_count = held_count + 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (held_count >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					item_mem[slot_at(int'(held_count))] = value;
					held_count = held_count + 1'b1;
				end
			end
			REQ_DROP_FRONT: begin
				// an overdrop still moves the head past every held item
				if (amount > held_count) begin
					head_slot = slot_at(int'(held_count));
					held_count = '0;
					r.status = ST_UNDERFLOW;
				end else begin
					head_slot = slot_at(int'(amount));
					held_count = held_count - amount;
				end
			end
			REQ_DROP_BACK: begin
				if (amount > held_count) begin
					held_count = '0;
					r.status = ST_UNDERFLOW;
				end else begin
					held_count = held_count - amount;
				end
			end
			REQ_READ: begin
				if (pos >= held_count)
					r.status = ST_RANGE;
				else
					r.read_value = item_mem[slot_at(int'(pos))];
			end
			REQ_WRITE: begin
				if (pos >= held_count)
					r.status = ST_RANGE;
				else
					item_mem[slot_at(int'(pos))] = value;
			end
			default: ;
		endcase
		r.used_count = held_count;
		return r;
	endfunction

	always @(posedge clk) begin : watch
		deiq_result_t got;
		deiq_result_t want;
		int bad;
		bad = 0;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.read_value = m_tdata[DATA_W-1:0];
				got.status     = status_t'(m_tdata[DATA_W +: STATUS_W]);
				got.used_count = m_tdata[DATA_W+STATUS_W +: CNT_W];
				if (expected_results.size() == 0) begin
					$error("result beat with no request outstanding");
					bad++;
				end else begin
					want = expected_results.pop_front();
					if (got.read_value !== want.read_value) begin
						$error("read_value: expected %0d, actual %0d",
							$signed(want.read_value), $signed(got.read_value));
						bad++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						bad++;
					end
					if (got.used_count !== want.used_count) begin
						$error("used_count: expected %0d, actual %0d",
							want.used_count, got.used_count);
						bad++;
					end
				end
				rsps <= rsps + 1;
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(apply_request(s_tuser, s_tdata[DATA_W-1:0],
					s_tdata[DATA_W +: IDX_W], s_tdata[DATA_W+IDX_W +: CNT_W]));
				reqs <= reqs + 1;
			end
		end
		fails <= fails + bad;
	end

endmodule

/* tb/double_ended_indexed_queue_unit_tb.sv */
`timescale 1ns / 100ps

module double_ended_indexed_queue_unit_tb;
	import deiq_pkg::*;

	localparam int DEPTH     = DEPTH_DEF;
	localparam int DATA_W    = DATA_WIDTH_DEF;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int S_TDATA_W = ((DATA_W + IDX_W + CNT_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((DATA_W + STATUS_W + CNT_W + 7) / 8) * 8;

	// request codes the block leaves undecoded
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	localparam int IDLE_PCT    = 10;
	localparam int QUIET_LO    = 900;
	localparam int QUIET_HI    = 1300;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 200;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// data_value, position, drop_amount (low to high), zero padded
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	// req_type
	logic [REQ_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// read_value, status, used_count (low to high), zero padded
	logic [M_TDATA_W-1:0]   m_tdata;

	int fail_count;
	int req_beats;
	int rsp_beats;
	int cyc = 0;
	int sent = 0;
	int directed_sent = 0;
	int held = 0;
	int peak_held = 0;

	double_ended_indexed_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	deiq_result_checker #(
		.S_W (S_TDATA_W),
		.M_W (M_TDATA_W)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.req_beats  (req_beats),
		.rsp_beats  (rsp_beats)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	function automatic logic quiet_window();
		return cyc >= QUIET_LO && cyc < QUIET_HI;
	endfunction

	// Offer one request beat and hold it until accepted; track the fill level
	// to steer positions, drop sizes and the fill loop, and to record its peak.
	task automatic send_req(
		input logic [REQ_W-1:0]  kind,
		input logic [DATA_W-1:0] value,
		input logic [IDX_W-1:0]  pos,
		input logic [CNT_W-1:0]  amt
	);
		while (!quiet_window() && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(S_TDATA_W - DATA_W - IDX_W - CNT_W){1'b0}}, amt, pos, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		case (kind)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: if (held < DEPTH) held++;
			REQ_DROP_FRONT, REQ_DROP_BACK: held = (int'(amt) > held) ? 0 : held - int'(amt);
			default: ;
		endcase
		if (held > peak_held)
			peak_held = held;
	endtask

	task automatic random_req(input int push_pct, input int drop_pct, input int access_pct);
		int roll;
		logic [REQ_W-1:0] kind;
		logic [IDX_W-1:0] pos;
		logic [CNT_W-1:0] amt;
		roll = $urandom_range(99);
		if (roll < push_pct)
			kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
		else if (roll < push_pct + drop_pct)
			kind = $urandom_range(1) ? REQ_DROP_BACK : REQ_DROP_FRONT;
		else if (roll < push_pct + drop_pct + access_pct)
			kind = $urandom_range(1) ? REQ_WRITE : REQ_READ;
		else
			kind = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
		// mostly land inside the held range
		if (held > 0 && $urandom_range(9) < 8)
			pos = IDX_W'($urandom_range(held - 1));
		else
			pos = IDX_W'($urandom_range(DEPTH - 1));
		roll = $urandom_range(9);
		if (roll < 7)
			amt = CNT_W'($urandom_range(8));
		else if (roll < 9)
			amt = CNT_W'($urandom_range(held));
		else
			amt = CNT_W'($urandom_range(DEPTH));
		send_req(kind, $urandom, pos, amt);
	endtask

	// Receiver: random stalls, one long hold-off, one stall-free window.
	initial begin : sink
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cyc == HOLD_AT)
				stall_left = HOLD_CYCLES;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (quiet_window()) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: range errors, zero drop, underflow
		send_req(REQ_READ, $urandom, 10'd0, CNT_W'($urandom_range(DEPTH)));
		send_req(REQ_WRITE, $urandom, 10'd0, CNT_W'($urandom_range(DEPTH)));
		send_req(REQ_DROP_FRONT, $urandom, IDX_W'($urandom_range(DEPTH - 1)), 11'd0);
		send_req(REQ_DROP_BACK, $urandom, IDX_W'($urandom_range(DEPTH - 1)), 11'd5);
		// extremes of the data, head wraps below slot zero
		send_req(REQ_PUSH_BACK, 32'h7fff_ffff, IDX_W'($urandom_range(DEPTH - 1)), 11'd0);
		send_req(REQ_PUSH_FRONT, 32'h8000_0000, IDX_W'($urandom_range(DEPTH - 1)), 11'd0);
		send_req(REQ_PUSH_BACK, 32'hffff_ffff, 10'd0, 11'd0);
		send_req(REQ_PUSH_FRONT, 32'h0000_0000, 10'd0, 11'd0);
		for (int i = 0; i < 4; i++)
			send_req(REQ_READ, $urandom, IDX_W'(i), CNT_W'($urandom_range(DEPTH)));
		send_req(REQ_WRITE, 32'h5555_5555, 10'd3, 11'd0);
		send_req(REQ_READ, $urandom, 10'd3, 11'd0);
		send_req(REQ_READ, $urandom, 10'd4, 11'd0);
		send_req(REQ_READ, $urandom, 10'd1023, 11'd0);
		send_req(REQ_WRITE, 32'haaaa_aaaa, 10'd1023, 11'd0);
		send_req(REQ_DROP_FRONT, $urandom, 10'd0, 11'd1);
		send_req(REQ_DROP_BACK, $urandom, 10'd0, 11'd1);
		// overdrop from the front with an amount equal to the depth
		send_req(REQ_DROP_FRONT, $urandom, 10'd0, 11'd1024);
		send_req(REQ_PUSH_BACK, 32'haaaa_aaaa, 10'd0, 11'd0);
		send_req(REQ_READ, $urandom, 10'd0, 11'd0);
		send_req(REQ_SPARE_LO, $urandom, IDX_W'($urandom_range(DEPTH - 1)),
			CNT_W'($urandom_range(DEPTH)));
		send_req(REQ_SPARE_HI, 32'hffff_ffff, 10'h3ff, 11'h7ff);
		send_req(REQ_DROP_BACK, $urandom, 10'd0, 11'd0);
		directed_sent = sent;

		repeat (250)
			random_req(40, 15, 40);
		// fill to capacity, then push against the full queue
		while (held < DEPTH)
			random_req(90, 0, 10);
		repeat (20)
			random_req(70, 0, 30);
		send_req(REQ_DROP_FRONT, $urandom, 10'd0, CNT_W'(held));
		repeat (60)
			random_req(35, 15, 40);

		s_tvalid <= 1'b0;
		while (rsp_beats != req_beats)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests (%0d directed), checked %0d results.",
			sent, directed_sent, rsp_beats);
		$display("Queue filled to %0d of %0d; output held off for %0d cycles.",
			peak_held, DEPTH, HOLD_CYCLES);
		if (fail_count == 0 && rsp_beats == req_beats)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#400_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* double_ended_indexed_queue_unit.f */
+incdir+rtl/core
rtl/core/deiq_pkg.sv
rtl/core/double_ended_indexed_queue_unit.sv
rtl/core/deiq_checker.sv
tb/deiq_result_checker.sv
tb/double_ended_indexed_queue_unit_tb.sv
